// ----- sv/cbpe_pkg.sv -----
// Package for the cubic Bezier point evaluator.
// Holds sequencer state types, fixed field widths and reset constants.
// No dependencies; every other file imports it.
package cbpe_pkg;

   // Fixed widths of the interface fields.
   localparam int PIX_BITS      = 9;
   localparam int PARAM_T_BITS  = 17;
   localparam int OUT_BITS      = 16;
   localparam int OUT_FRAC_BITS = 7;

   // Width of one slice of the Horner value fed to the shared multiplier.
   localparam int LIMB_BITS = 16;

   // Largest result code; larger values saturate here.
   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   // Reset values of the window height and the control point ring.
   localparam logic [PIX_BITS-1:0] WIN_HEIGHT_RESET = 9'd500;
   localparam logic [PIX_BITS-1:0] CTRL_X_RESET [4] = '{9'd100, 9'd200, 9'd300, 9'd400};
   localparam logic [PIX_BITS-1:0] CTRL_Y_RESET [4] = '{9'd200, 9'd50, 9'd120, 9'd350};

   // Input operation codes.
   localparam logic OP_CLICK = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Index of the last Horner step.
   localparam logic [1:0] LAST_STEP = 2'd2;

   // Sequencer of the shared multiply-accumulate unit.
   typedef enum logic [1:0] {
      EV_IDLE,
      EV_MUL,
      EV_DONE
   } eval_state_type;

   // Item-level control of the top level.
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_EVAL_X,
      TOP_EVAL_Y,
      TOP_DELIVER
   } top_state_type;

endpackage

// ----- sv/cubic_bezier_point_evaluator.sv -----
// Top level of the cubic Bezier point evaluator: control point ring, window height
// register, item sequencing and the result register. Depends on cbpe_pkg and cbpe_eval.
//
// A click transfer with left_press set stores the click (y flipped against window
// height, floored at zero) into the next slot of a four-point ring and gives no
// result. An evaluate transfer returns the curve point at t (Q1.16, clamped to 1.0)
// in Q9.7, rounded to nearest. Both coordinates, x and then y, go through one shared
// multiply-accumulate unit that runs Horner's rule slice by slice over
// NL = ceil((COORD_BITS + 3*T_FRAC_BITS) / 16) slices. The input is held while both
// passes run and is taken again as soon as the result sits in the output register,
// even while that result waits to be taken.
module cubic_bezier_point_evaluator
   import cbpe_pkg::*;
#(
   parameter int COORD_BITS  = 9,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_op,
   input  logic                    req_left_press,
   input  logic [PIX_BITS-1:0]     req_click_x,
   input  logic [PIX_BITS-1:0]     req_click_y,
   input  logic [PARAM_T_BITS-1:0] req_param_t,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [OUT_BITS-1:0]     rsp_point_x,
   output logic [OUT_BITS-1:0]     rsp_point_y,
   input  logic                    csr_write_en,
   input  logic [PIX_BITS-1:0]     csr_write_data
);

   localparam int TW  = T_FRAC_BITS + 1;
   localparam int CMW = (TW > PARAM_T_BITS) ? TW : PARAM_T_BITS;
   localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   top_state_type          state_ff, state_in;
   logic [PIX_BITS-1:0]    win_h_ff, win_h_in;
   logic [COORD_BITS-1:0]  ctrl_x_ff [4];
   logic [COORD_BITS-1:0]  ctrl_x_in [4];
   logic [COORD_BITS-1:0]  ctrl_y_ff [4];
   logic [COORD_BITS-1:0]  ctrl_y_in [4];
   logic [1:0]             slot_ff, slot_in;
   logic [TW-1:0]          t_ff, t_in;
   logic [OUT_BITS-1:0]    x_res_ff, x_res_in;
   logic [OUT_BITS-1:0]    y_res_ff, y_res_in;
   logic [OUT_BITS-1:0]    rsp_x_ff, rsp_x_in;
   logic [OUT_BITS-1:0]    rsp_y_ff, rsp_y_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_xfer;
   logic [PIX_BITS-1:0]    flip_y;
   logic                   sel_y;
   logic                   eval_start;
   logic                   eval_done;
   logic [OUT_BITS-1:0]    eval_result;
   logic [COORD_BITS-1:0]  pts_sel [4];

   assign req_ready = (state_ff == TOP_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Flip the click row into curve space, floored at zero.
   assign flip_y = (req_click_y > win_h_ff) ? '0 : win_h_ff - req_click_y;

   // The y points feed the unit from the cycle that starts the y pass.
   assign sel_y = (state_ff == TOP_EVAL_Y) || ((state_ff == TOP_EVAL_X) && eval_done);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pts_sel[i] = sel_y ? ctrl_y_ff[i] : ctrl_x_ff[i];
      end
   end

   // Item sequencing, ring update and the result register.
   always_comb begin
      state_in     = state_ff;
      win_h_in     = csr_write_en ? csr_write_data : win_h_ff;
      ctrl_x_in    = ctrl_x_ff;
      ctrl_y_in    = ctrl_y_ff;
      slot_in      = slot_ff;
      t_in         = t_ff;
      x_res_in     = x_res_ff;
      y_res_in     = y_res_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      eval_start   = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_EVAL) begin
                  t_in       = (CMW'(req_param_t) > CMW'(T_ONE)) ? T_ONE : TW'(req_param_t);
                  eval_start = 1'b1;
                  state_in   = TOP_EVAL_X;
               end else if (req_left_press) begin
                  ctrl_x_in[slot_ff] = COORD_BITS'(req_click_x);
                  ctrl_y_in[slot_ff] = COORD_BITS'(flip_y);
                  slot_in            = slot_ff + 2'd1;
               end
            end
         end
         TOP_EVAL_X: begin
            if (eval_done) begin
               x_res_in   = eval_result;
               eval_start = 1'b1;
               state_in   = TOP_EVAL_Y;
            end
         end
         TOP_EVAL_Y: begin
            if (eval_done) begin
               y_res_in = eval_result;
               state_in = TOP_DELIVER;
            end
         end
         TOP_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_x_in     = x_res_ff;
               rsp_y_in     = y_res_ff;
               rsp_valid_in = 1'b1;
               state_in     = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // Control state and the point ring reset to their defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         win_h_ff     <= WIN_HEIGHT_RESET;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            ctrl_x_ff[i] <= COORD_BITS'(CTRL_X_RESET[i]);
            ctrl_y_ff[i] <= COORD_BITS'(CTRL_Y_RESET[i]);
         end
      end else begin
         state_ff     <= state_in;
         win_h_ff     <= win_h_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_x_ff    <= ctrl_x_in;
         ctrl_y_ff    <= ctrl_y_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      x_res_ff <= x_res_in;
      y_res_ff <= y_res_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   cbpe_eval #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_eval (
      .clock    (clock),
      .reset    (reset),
      .start_i  (eval_start),
      .t_i      (t_ff),
      .pts_i    (pts_sel),
      .done_o   (eval_done),
      .result_o (eval_result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;

endmodule

// ----- sv/cbpe_eval.sv -----
// Iterative evaluator of one cubic Bezier coordinate by Horner's rule.
// One shared limb-by-t multiplier and one wide accumulator under a small sequencer.
// Depends on cbpe_pkg.
module cbpe_eval
   import cbpe_pkg::*;
#(
   parameter int COORD_BITS  = 9,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_i,
   input  logic [T_FRAC_BITS:0]  t_i,
   input  logic [COORD_BITS-1:0] pts_i [4],
   output logic                  done_o,
   output logic [OUT_BITS-1:0]   result_o
);

   // The exact sum fits in COORD_BITS + 3*T_FRAC_BITS bits; all work is modulo that.
   localparam int TW   = T_FRAC_BITS + 1;
   localparam int W    = COORD_BITS + 3 * T_FRAC_BITS;
   localparam int NL   = (W + LIMB_BITS - 1) / LIMB_BITS;
   localparam int LCW  = $clog2(NL);
   localparam int PW   = LIMB_BITS + TW;
   localparam int PSW  = NL * LIMB_BITS + PW;
   localparam int CW   = COORD_BITS + 4;
   localparam int SH   = 3 * T_FRAC_BITS - OUT_FRAC_BITS;
   localparam int RW   = W - SH;
   localparam int RXW  = (RW > OUT_BITS) ? RW : OUT_BITS + 1;
   localparam logic [W-1:0]   ROUND_HALF = W'(1) << (SH - 1);
   localparam logic [LCW-1:0] LAST_LIMB  = LCW'(NL - 1);

   eval_state_type        state_ff, state_in;
   logic [W-1:0]          h_ff, h_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [1:0]            step_ff, step_in;
   logic [LCW-1:0]        limb_ff, limb_in;

   logic signed [CW-1:0]  p0, p1, p2, p3;
   logic signed [CW-1:0]  d10, e012, d12;
   logic signed [CW-1:0]  a0, a1, a2, a3;
   logic [W-1:0]          a3_ext;
   logic [W-1:0]          term0, term1, term2;
   logic [NL*LIMB_BITS-1:0] h_pad;
   logic [LIMB_BITS-1:0]  limb;
   logic [PW-1:0]         prod;
   logic [W-1:0]          prod_sh;
   logic [W-1:0]          acc_sum;
   logic [W-1:0]          h_round;
   logic [RXW-1:0]        r_ext;

   // Power-basis coefficients: B(t) = a3 t^3 + a2 t^2 + a1 t + a0 with t scaled by one.
   always_comb begin
      p0   = $signed(CW'(pts_i[0]));
      p1   = $signed(CW'(pts_i[1]));
      p2   = $signed(CW'(pts_i[2]));
      p3   = $signed(CW'(pts_i[3]));
      d10  = p1 - p0;
      e012 = p0 - (p1 <<< 1) + p2;
      d12  = p1 - p2;
      a0   = p0;
      a1   = (d10 <<< 1) + d10;
      a2   = (e012 <<< 1) + e012;
      a3   = p3 - p0 + (d12 <<< 1) + d12;
   end

   // Constant terms added at the start of each Horner step, pre-scaled by powers of one.
   always_comb begin
      a3_ext = {{(W - CW){a3[CW-1]}}, a3};
      term0  = W'({{(W - CW){a2[CW-1]}}, a2} << T_FRAC_BITS);
      term1  = W'({{(W - CW){a1[CW-1]}}, a1} << (2 * T_FRAC_BITS));
      term2  = W'({{(W - CW){a0[CW-1]}}, a0} << (3 * T_FRAC_BITS));
   end

   // Shared multiplier: one slice of the Horner value times t, aligned into the accumulator.
   always_comb begin
      h_pad   = (NL * LIMB_BITS)'(h_ff);
      limb    = h_pad[limb_ff * LIMB_BITS +: LIMB_BITS];
      prod    = PW'(limb) * PW'(t_i);
      prod_sh = W'(PSW'(prod) << (limb_ff * LIMB_BITS));
      acc_sum = acc_ff + prod_sh;
   end

   // Sequencer: three Horner steps, each one multiply-accumulate per slice of the value.
   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      limb_in  = limb_ff;
      case (state_ff)
         EV_IDLE, EV_DONE: begin
            if (start_i) begin
               h_in     = a3_ext;
               acc_in   = term0;
               step_in  = '0;
               limb_in  = '0;
               state_in = EV_MUL;
            end else begin
               state_in = EV_IDLE;
            end
         end
         EV_MUL: begin
            if (limb_ff == LAST_LIMB) begin
               limb_in = '0;
               h_in    = acc_sum;
               if (step_ff == LAST_STEP) begin
                  state_in = EV_DONE;
               end else begin
                  step_in = step_ff + 2'd1;
                  acc_in  = (step_ff == 2'd0) ? term1 : term2;
               end
            end else begin
               acc_in  = acc_sum;
               limb_in = limb_ff + LCW'(1);
            end
         end
         default: begin
            state_in = EV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      limb_ff <= limb_in;
   end

   // Round to nearest Q9.7 with ties up, then saturate to the result width.
   always_comb begin
      h_round  = h_ff + ROUND_HALF;
      r_ext    = RXW'(h_round[W-1:SH]);
      result_o = (|r_ext[RXW-1:OUT_BITS]) ? OUT_MAX : r_ext[OUT_BITS-1:0];
   end

   assign done_o = (state_ff == EV_DONE);

endmodule
